/* sv/bssc_pkg.sv */
// Package: widths, codes, configuration types and commutation tables.
package bssc_pkg;

    localparam int CmdW    = 3;
    localparam int DutyW   = 8;
    localparam int MarginW = 7;
    localparam int PeriodW = 16;
    localparam int StepW   = 10;
    localparam int LevelW  = 4;
    localparam int PhaseW  = 3;
    localparam int DriveW  = 6;
    localparam int SenseW  = 2;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;

    localparam logic [PhaseW-1:0] LastPhase = 3'd5;

    typedef enum logic [CmdW-1:0] {
        CMD_TICK      = 3'd0,
        CMD_ENABLE    = 3'd1,
        CMD_SET_DUTY  = 3'd2,
        CMD_DISABLE   = 3'd3,
        CMD_COMMUTATE = 3'd4
    } bssc_cmd_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MAX_DUTY     = 3'd0,
        REG_CLAMP_MARGIN = 3'd1,
        REG_START_PERIOD = 3'd2,
        REG_END_PERIOD   = 3'd3,
        REG_PERIOD_STEP  = 3'd4,
        REG_STEPS_LEVEL  = 3'd5
    } bssc_reg_idx_t;

    localparam logic [DutyW-1:0]   MaxDutyRst     = 8'd249;
    localparam logic [MarginW-1:0] ClampMarginRst = 7'd15;
    localparam logic [PeriodW-1:0] StartPeriodRst = 16'd5000;
    localparam logic [PeriodW-1:0] EndPeriodRst   = 16'd500;
    localparam logic [StepW-1:0]   PeriodStepRst  = 10'd10;
    localparam logic [LevelW-1:0]  StepsLevelRst  = 4'd6;

    typedef struct packed {
        logic [DutyW-1:0]   max_duty;
        logic [MarginW-1:0] clamp_margin;
        logic [PeriodW-1:0] spinup_start_period;
        logic [PeriodW-1:0] spinup_end_period;
        logic [StepW-1:0]   spinup_period_step;
        logic [LevelW-1:0]  steps_per_level;
    } bssc_cfg_t;

    typedef struct packed {
        logic [DriveW-1:0] drive_pattern;
        logic [SenseW-1:0] sense_phase;
        logic              sense_rising;
        logic [DutyW-1:0]  duty_out;
        logic              running;
        logic              spinning_up;
        logic              accepted;
    } bssc_res_t;

    function automatic logic [PhaseW-1:0] next_phase(input logic [PhaseW-1:0] p);
        next_phase = (p >= LastPhase) ? '0 : p + 3'd1;
    endfunction

    function automatic logic [DriveW-1:0] drive_lookup(input logic [PhaseW-1:0] p);
        case (p)
            3'd0:    drive_lookup = 6'h24;
            3'd1:    drive_lookup = 6'h21;
            3'd2:    drive_lookup = 6'h09;
            3'd3:    drive_lookup = 6'h18;
            3'd4:    drive_lookup = 6'h12;
            3'd5:    drive_lookup = 6'h06;
            default: drive_lookup = 6'h24;
        endcase
    endfunction

    function automatic logic [SenseW-1:0] sense_phase_lookup(input logic [PhaseW-1:0] p);
        case (p)
            3'd0, 3'd3: sense_phase_lookup = 2'd2;
            3'd1, 3'd4: sense_phase_lookup = 2'd1;
            3'd2, 3'd5: sense_phase_lookup = 2'd0;
            default:    sense_phase_lookup = 2'd2;
        endcase
    endfunction

    function automatic logic sense_rising_lookup(input logic [PhaseW-1:0] p);
        case (p)
            3'd1, 3'd3, 3'd5: sense_rising_lookup = 1'b1;
            default:          sense_rising_lookup = 1'b0;
        endcase
    endfunction

endpackage

/* sv/bssc_cmd_if.sv */
// Interface: command channel carrying cmd and duty_request.
interface bssc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [bssc_pkg::CmdW-1:0]     cmd;
    logic [bssc_pkg::DutyW-1:0]    duty_request;

    modport source (output valid, output cmd, output duty_request, input ready);
    modport sink   (input valid, input cmd, input duty_request, output ready);
endinterface

/* sv/bssc_res_if.sv */
// Interface: result channel carrying drive, sense and status fields.
interface bssc_res_if;
    logic                          valid;
    logic                          ready;
    logic [bssc_pkg::DriveW-1:0]   drive_pattern;
    logic [bssc_pkg::SenseW-1:0]   sense_phase;
    logic                          sense_rising;
    logic [bssc_pkg::DutyW-1:0]    duty_out;
    logic                          running;
    logic                          spinning_up;
    logic                          accepted;

    modport source (output valid, output drive_pattern, output sense_phase,
                    output sense_rising, output duty_out, output running,
                    output spinning_up, output accepted, input ready);
    modport sink   (input valid, input drive_pattern, input sense_phase,
                    input sense_rising, input duty_out, input running,
                    input spinning_up, input accepted, output ready);
endinterface

/* sv/bssc_cfg_regs.sv */
// Configuration register file with write-only access.
module bssc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bssc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bssc_pkg::CfgDatW-1:0]   cfg_data,
    output bssc_pkg::bssc_cfg_t            cfg
);

    bssc_pkg::bssc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_duty            <= bssc_pkg::MaxDutyRst;
            cfg_reg.clamp_margin        <= bssc_pkg::ClampMarginRst;
            cfg_reg.spinup_start_period <= bssc_pkg::StartPeriodRst;
            cfg_reg.spinup_end_period   <= bssc_pkg::EndPeriodRst;
            cfg_reg.spinup_period_step  <= bssc_pkg::PeriodStepRst;
            cfg_reg.steps_per_level     <= bssc_pkg::StepsLevelRst;
        end
        else if (cfg_wr_en)
        begin
            case (bssc_pkg::bssc_reg_idx_t'(cfg_index))
                bssc_pkg::REG_MAX_DUTY:
                    cfg_reg.max_duty <= cfg_data[bssc_pkg::DutyW-1:0];
                bssc_pkg::REG_CLAMP_MARGIN:
                    cfg_reg.clamp_margin <= cfg_data[bssc_pkg::MarginW-1:0];
                bssc_pkg::REG_START_PERIOD:
                    cfg_reg.spinup_start_period <= cfg_data[bssc_pkg::PeriodW-1:0];
                bssc_pkg::REG_END_PERIOD:
                    cfg_reg.spinup_end_period <= cfg_data[bssc_pkg::PeriodW-1:0];
                bssc_pkg::REG_PERIOD_STEP:
                    cfg_reg.spinup_period_step <= cfg_data[bssc_pkg::StepW-1:0];
                bssc_pkg::REG_STEPS_LEVEL:
                    cfg_reg.steps_per_level <= cfg_data[bssc_pkg::LevelW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/bssc_ctrl.sv */
// Commutation state and per-command update, with the result of each command.
module bssc_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [bssc_pkg::CmdW-1:0]      cmd,
    input  logic [bssc_pkg::DutyW-1:0]     duty_request,
    input  bssc_pkg::bssc_cfg_t            cfg,
    output bssc_pkg::bssc_res_t            res
);

    logic [bssc_pkg::PhaseW-1:0]  phase_reg,  phase_next;
    logic                         run_reg,    run_next;
    logic                         wind_reg,   wind_next;
    logic [bssc_pkg::PeriodW-1:0] period_reg, period_next;
    logic [bssc_pkg::PeriodW-1:0] tick_reg,   tick_next;
    logic [bssc_pkg::LevelW-1:0]  level_reg,  level_next;
    logic [bssc_pkg::DutyW-1:0]   duty_reg,   duty_next;

    logic                         accepted;
    logic [bssc_pkg::PeriodW-1:0] tick_inc;
    logic [bssc_pkg::LevelW-1:0]  level_inc;
    logic [bssc_pkg::LevelW-1:0]  per_level;
    logic [bssc_pkg::PeriodW-1:0] step_ext;
    logic [bssc_pkg::PeriodW-1:0] period_dec;
    logic signed [9:0]            clamp_thr;
    logic                         req_low;
    logic [bssc_pkg::DutyW-1:0]   req_clamped;
    logic                         pend_low;
    logic [bssc_pkg::DutyW-1:0]   pend_clamped;
    logic [bssc_pkg::PhaseW-1:0]  p_out;
    logic                         active;

    // Duty check: too low below the margin, clamp to max at or above max - margin
    assign clamp_thr    = $signed({2'b00, cfg.max_duty}) - $signed({3'b000, cfg.clamp_margin});
    assign req_low      = duty_request < {1'b0, cfg.clamp_margin};
    assign req_clamped  = ($signed({2'b00, duty_request}) >= clamp_thr) ? cfg.max_duty
                                                                        : duty_request;
    assign pend_low     = duty_reg < {1'b0, cfg.clamp_margin};
    assign pend_clamped = ($signed({2'b00, duty_reg}) >= clamp_thr) ? cfg.max_duty : duty_reg;

    assign tick_inc   = tick_reg + 16'd1;
    assign level_inc  = level_reg + 4'd1;
    assign per_level  = (cfg.steps_per_level == '0) ? 4'd1 : cfg.steps_per_level;
    assign step_ext   = {{(bssc_pkg::PeriodW-bssc_pkg::StepW){1'b0}}, cfg.spinup_period_step};
    assign period_dec = (period_reg > step_ext) ? period_reg - step_ext : '0;

    always_comb
    begin
        phase_next  = phase_reg;
        run_next    = run_reg;
        wind_next   = wind_reg;
        period_next = period_reg;
        tick_next   = tick_reg;
        level_next  = level_reg;
        duty_next   = duty_reg;
        accepted    = 1'b0;

        case (bssc_pkg::bssc_cmd_t'(cmd))
            bssc_pkg::CMD_TICK:
            begin
                if (wind_reg)
                begin
                    accepted = 1'b1;
                    if (tick_inc < period_reg)
                    begin
                        tick_next = tick_inc;
                    end
                    else
                    begin
                        tick_next  = '0;
                        phase_next = bssc_pkg::next_phase(phase_reg);
                        level_next = level_inc;
                        if (level_inc >= per_level)
                        begin
                            level_next  = '0;
                            period_next = period_dec;
                            if (period_dec <= cfg.spinup_end_period)
                            begin
                                // spin-up done: run with the pending duty, or go idle if it is below the margin
                                wind_next = 1'b0;
                                if (pend_low)
                                begin
                                    run_next    = 1'b0;
                                    duty_next   = '0;
                                    period_next = '0;
                                end
                                else
                                begin
                                    run_next  = 1'b1;
                                    duty_next = pend_clamped;
                                end
                            end
                        end
                    end
                end
            end
            bssc_pkg::CMD_ENABLE,
            bssc_pkg::CMD_SET_DUTY:
            begin
                if (run_reg || wind_reg ||
                    (bssc_pkg::bssc_cmd_t'(cmd) == bssc_pkg::CMD_ENABLE))
                begin
                    if (req_low)
                    begin
                        run_next    = 1'b0;
                        wind_next   = 1'b0;
                        duty_next   = '0;
                        period_next = '0;
                        tick_next   = '0;
                        level_next  = '0;
                    end
                    else
                    begin
                        accepted = 1'b1;
                        if (run_reg)
                        begin
                            duty_next = req_clamped;
                        end
                        else if (wind_reg)
                        begin
                            duty_next = duty_request;
                        end
                        else if (cfg.spinup_start_period <= cfg.spinup_end_period)
                        begin
                            // short spin-up: straight to running
                            run_next   = 1'b1;
                            tick_next  = '0;
                            level_next = '0;
                            duty_next  = req_clamped;
                        end
                        else
                        begin
                            wind_next   = 1'b1;
                            period_next = cfg.spinup_start_period;
                            tick_next   = '0;
                            level_next  = '0;
                            duty_next   = duty_request;
                        end
                    end
                end
            end
            bssc_pkg::CMD_DISABLE:
            begin
                accepted    = 1'b1;
                run_next    = 1'b0;
                wind_next   = 1'b0;
                duty_next   = '0;
                period_next = '0;
                tick_next   = '0;
                level_next  = '0;
            end
            bssc_pkg::CMD_COMMUTATE:
            begin
                if (run_reg)
                begin
                    accepted   = 1'b1;
                    phase_next = bssc_pkg::next_phase(phase_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            run_reg    <= 1'b0;
            wind_reg   <= 1'b0;
            period_reg <= '0;
            tick_reg   <= '0;
            level_reg  <= '0;
            duty_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            run_reg    <= run_next;
            wind_reg   <= wind_next;
            period_reg <= period_next;
            tick_reg   <= tick_next;
            level_reg  <= level_next;
            duty_reg   <= duty_next;
        end
    end

    // Outputs reflect the state after the command
    assign p_out  = (phase_next > bssc_pkg::LastPhase) ? '0 : phase_next;
    assign active = run_next || wind_next;

    always_comb
    begin
        res.drive_pattern = active ? bssc_pkg::drive_lookup(p_out) : '0;
        res.sense_phase   = run_next ? bssc_pkg::sense_phase_lookup(p_out) : '0;
        res.sense_rising  = run_next && bssc_pkg::sense_rising_lookup(p_out);
        res.duty_out      = run_next ? duty_next : '0;
        res.running       = run_next;
        res.spinning_up   = wind_next;
        res.accepted      = accepted;
    end

endmodule

/* sv/bldc_six_step_commutator.sv */
// Top level: six-step BLDC commutation controller with registered command and result.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+----------------------------------------------
//  item     | in  | valid/ready  | cmd[2:0], duty_request[7:0]
//  result   | out | valid/ready  | drive_pattern[5:0], sense_phase[1:0],
//           |     |              | sense_rising, duty_out[7:0], running,
//           |     |              | spinning_up, accepted
//  cfg      | in  | write enable | cfg_index[2:0], cfg_data[15:0]
//
// One transaction per clock sustained while the result side keeps ready high; an
// accepted command passes through the command register and then the result
// register, with the state update in between.
// Reset clears the commutation state and loads the configuration defaults.
// A stalled result holds the command register; a further transaction is still
// taken while the command register is empty.
module bldc_six_step_commutator (
    input  logic                           clk,
    input  logic                           rst_n,
    bssc_cmd_if.sink                       item,
    bssc_res_if.source                     result,
    input  logic                           cfg_wr_en,
    input  logic [bssc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bssc_pkg::CfgDatW-1:0]   cfg_data
);

    bssc_pkg::bssc_cfg_t          cfg;
    bssc_pkg::bssc_res_t          ctrl_res;

    logic                         in_valid_reg;
    logic [bssc_pkg::CmdW-1:0]    in_cmd_reg;
    logic [bssc_pkg::DutyW-1:0]   in_duty_reg;
    logic                         res_valid_reg;
    bssc_pkg::bssc_res_t          res_reg;

    logic                         in_take;
    logic                         advance;

    // Advance the held command whenever the result slot is free or emptying
    assign advance    = in_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign in_take    = item.valid && item.ready;

    bssc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bssc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .cmd          (in_cmd_reg),
        .duty_request (in_duty_reg),
        .cfg          (cfg),
        .res          (ctrl_res)
    );

    // Valid flags of the command and result stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers: load on a transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= item.cmd;
            in_duty_reg <= item.duty_request;
        end
        if (advance)
            res_reg <= ctrl_res;
    end

    assign result.valid         = res_valid_reg;
    assign result.drive_pattern = res_reg.drive_pattern;
    assign result.sense_phase   = res_reg.sense_phase;
    assign result.sense_rising  = res_reg.sense_rising;
    assign result.duty_out      = res_reg.duty_out;
    assign result.running       = res_reg.running;
    assign result.spinning_up   = res_reg.spinning_up;
    assign result.accepted      = res_reg.accepted;

endmodule

/* tb/sv/bssc_scoreboard_pkg.sv */
// Scoreboard for the six-step commutator: commutation state mirror and result checking.
`timescale 1ns / 100ps
package bssc_scoreboard_pkg;
    import bssc_pkg::*;

    class commutation_scoreboard;
        // configuration mirror
        logic [DutyW-1:0]   max_duty;
        logic [MarginW-1:0] clamp_margin;
        logic [PeriodW-1:0] start_period;
        logic [PeriodW-1:0] end_period;
        logic [StepW-1:0]   period_step;
        logic [LevelW-1:0]  level_len;

        // commutation state mirror
        logic [PhaseW-1:0]  phase_step;
        bit                 run_flag;
        bit                 windup_flag;
        logic [PeriodW-1:0] step_period;
        logic [PeriodW-1:0] tick_count;
        logic [LevelW-1:0]  level_count;
        logic [DutyW-1:0]   duty_value;

        bssc_res_t          predicted_outputs[$];
        int unsigned        mismatches;

        function new();
            max_duty     = MaxDutyRst;
            clamp_margin = ClampMarginRst;
            start_period = StartPeriodRst;
            end_period   = EndPeriodRst;
            period_step  = PeriodStepRst;
            level_len    = StepsLevelRst;
            phase_step   = '0;
            mismatches   = 0;
            go_idle();
        endfunction

        function void write_register(bssc_reg_idx_t idx, logic [CfgDatW-1:0] value);
            case (idx)
                REG_MAX_DUTY:     max_duty     = value[DutyW-1:0];
                REG_CLAMP_MARGIN: clamp_margin = value[MarginW-1:0];
                REG_START_PERIOD: start_period = value[PeriodW-1:0];
                REG_END_PERIOD:   end_period   = value[PeriodW-1:0];
                REG_PERIOD_STEP:  period_step  = value[StepW-1:0];
                REG_STEPS_LEVEL:  level_len    = value[LevelW-1:0];
                default:          ;
            endcase
        endfunction

        function void go_idle();
            run_flag    = 1'b0;
            windup_flag = 1'b0;
            duty_value  = '0;
            step_period = '0;
            tick_count  = '0;
            level_count = '0;
        endfunction

        function logic [PhaseW-1:0] step_after(logic [PhaseW-1:0] p);
            return (p >= LastPhase) ? '0 : p + PhaseW'(1);
        endfunction

        function bit request_low(logic [DutyW-1:0] req);
            return req < {1'b0, clamp_margin};
        endfunction

        // Duty check: a low request drops the motor, a high one takes the ceiling.
        function bit apply_request(logic [DutyW-1:0] req);
            if (request_low(req))
            begin
                go_idle();
                return 1'b0;
            end
            if (int'(req) >= int'(max_duty) - int'(clamp_margin))
                duty_value = max_duty;
            else
                duty_value = req;
            return 1'b1;
        endfunction

        function bit replace_pending(logic [DutyW-1:0] req);
            if (request_low(req))
            begin
                go_idle();
                return 1'b0;
            end
            duty_value = req;
            return 1'b1;
        endfunction

        function bit begin_running(logic [DutyW-1:0] req);
            windup_flag = 1'b0;
            run_flag    = 1'b1;
            tick_count  = '0;
            level_count = '0;
            return apply_request(req);
        endfunction

        function void advance_spinup();
            logic [LevelW-1:0]  per_level;
            logic [PeriodW-1:0] step_ext;
            per_level  = (level_len == '0) ? LevelW'(1) : level_len;
            step_ext   = PeriodW'(period_step);
            tick_count = tick_count + PeriodW'(1);
            if (tick_count < step_period)
                return;
            tick_count  = '0;
            phase_step  = step_after(phase_step);
            level_count = level_count + LevelW'(1);
            if (level_count >= per_level)
            begin
                level_count = '0;
                step_period = (step_period > step_ext) ? step_period - step_ext : '0;
                if (step_period <= end_period)
                    void'(begin_running(duty_value));
            end
        endfunction

        function logic [DriveW-1:0] gate_pattern(logic [PhaseW-1:0] p);
            case (p)
                3'd0:    return 6'h24;
                3'd1:    return 6'h21;
                3'd2:    return 6'h09;
                3'd3:    return 6'h18;
                3'd4:    return 6'h12;
                default: return 6'h06;
            endcase
        endfunction

        function bssc_res_t outputs_now(bit acc);
            bssc_res_t         r;
            logic [PhaseW-1:0] p;
            p                = (phase_step <= LastPhase) ? phase_step : '0;
            r.drive_pattern  = (run_flag || windup_flag) ? gate_pattern(p) : '0;
            r.sense_phase    = run_flag ? SenseW'(2 - p % 3) : '0;
            r.sense_rising   = run_flag ? p[0] : 1'b0;
            r.duty_out       = run_flag ? duty_value : '0;
            r.running        = run_flag;
            r.spinning_up    = windup_flag;
            r.accepted       = acc;
            return r;
        endfunction

        // Note an accepted command; returns whether it is predicted to take effect.
        function bit note_command(logic [CmdW-1:0] code, logic [DutyW-1:0] req);
            bit acc;
            acc = 1'b0;
            case (code)
                CMD_TICK:
                    if (windup_flag)
                    begin
                        advance_spinup();
                        acc = 1'b1;
                    end
                CMD_ENABLE:
                    if (run_flag)
                        acc = apply_request(req);
                    else if (windup_flag)
                        acc = replace_pending(req);
                    else if (request_low(req))
                        go_idle();
                    else if (start_period <= end_period)
                        acc = begin_running(req);
                    else
                    begin
                        windup_flag = 1'b1;
                        step_period = start_period;
                        tick_count  = '0;
                        level_count = '0;
                        duty_value  = req;
                        acc         = 1'b1;
                    end
                CMD_SET_DUTY:
                    if (run_flag)
                        acc = apply_request(req);
                    else if (windup_flag)
                        acc = replace_pending(req);
                CMD_DISABLE:
                begin
                    go_idle();
                    acc = 1'b1;
                end
                CMD_COMMUTATE:
                    if (run_flag)
                    begin
                        phase_step = step_after(phase_step);
                        acc        = 1'b1;
                    end
                default: ;
            endcase
            predicted_outputs.push_back(outputs_now(acc));
            return acc;
        endfunction

        function int unsigned outstanding();
            return predicted_outputs.size();
        endfunction

        task report_mismatch(string text);
            $display("MISMATCH at %0t: %s", $time, text);
            mismatches++;
        endtask

        task compare_field(string name, logic [7:0] seen, logic [7:0] want);
            if (seen !== want)
                report_mismatch($sformatf("%s expected %0d, seen %0d", name, want, seen));
        endtask

        task check_result(bssc_res_t seen);
            bssc_res_t want;
            if (predicted_outputs.size() == 0)
            begin
                report_mismatch("result transaction with nothing outstanding");
                return;
            end
            want = predicted_outputs.pop_front();
            compare_field("drive_pattern", 8'(seen.drive_pattern), 8'(want.drive_pattern));
            compare_field("sense_phase", 8'(seen.sense_phase), 8'(want.sense_phase));
            compare_field("sense_rising", 8'(seen.sense_rising), 8'(want.sense_rising));
            compare_field("duty_out", seen.duty_out, want.duty_out);
            compare_field("running", 8'(seen.running), 8'(want.running));
            compare_field("spinning_up", 8'(seen.spinning_up), 8'(want.spinning_up));
            compare_field("accepted", 8'(seen.accepted), 8'(want.accepted));
        endtask
    endclass

endpackage

/* tb/sv/testbench.sv */
// Testbench top: drives commands and configuration into the commutator and checks results.
`timescale 1ns / 100ps
module testbench;
    import bssc_pkg::*;
    import bssc_scoreboard_pkg::*;

    // Cycles without any transaction on either channel before the run is abandoned.
    // The longest legitimate quiet stretch is the deliberate receiver hold-off
    // plus a drain and a register update.
    localparam int WatchdogLimit = 2000;
    localparam int HoldOffCycles = 60;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDatW-1:0]  cfg_data;

    bssc_cmd_if          cmd_bus ();
    bssc_res_if          result_bus ();

    commutation_scoreboard sb;

    bit                  gaps_on;        // sender inserts idle bursts
    bit                  stalls_on;      // receiver inserts stall bursts
    int                  hold_off_len;   // request for one long receiver hold-off
    int unsigned         useful_count;   // commands predicted to take effect
    int                  quiet_cycles = 0;
    bssc_res_t           seen_result;

    bldc_six_step_commutator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (cmd_bus),
        .result    (result_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: hold ready high, drop it in short random bursts, and on request
    // hold it low for a long stretch so that both pipeline registers fill
    // and the block has to stall the command channel.
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                result_bus.ready <= 1'b0;
                for (int k = 0; k < hold_off_len; k++)
                    @(posedge clk);
                hold_off_len = 0;
                result_bus.ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                result_bus.ready <= 1'b1;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // Result monitor and watchdog. Sample at the rising edge, so every value
    // seen here is the one the block presented in the cycle just ended.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                seen_result.drive_pattern = result_bus.drive_pattern;
                seen_result.sense_phase   = result_bus.sense_phase;
                seen_result.sense_rising  = result_bus.sense_rising;
                seen_result.duty_out      = result_bus.duty_out;
                seen_result.running       = result_bus.running;
                seen_result.spinning_up   = result_bus.spinning_up;
                seen_result.accepted      = result_bus.accepted;
                sb.check_result(seen_result);
            end
            if ((cmd_bus.valid && cmd_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WatchdogLimit)
            begin
                $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one command and hold it until the block takes it. The prediction is
    // updated here, at the accepting edge, so the next pick sees current state.
    task automatic send_command(input logic [CmdW-1:0] code, input logic [DutyW-1:0] req);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.cmd          <= code;
        cmd_bus.duty_request <= req;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_bus.ready);
        if (sb.note_command(code, req))
            useful_count++;
    endtask

    // Drop valid and wait until every outstanding result has come back, then
    // let the two-stage pipeline settle.
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input bssc_reg_idx_t idx, input logic [CfgDatW-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_register(idx, value);
    endtask

    // Write the whole register set with the block drained.
    task automatic program_settings(input logic [CfgDatW-1:0] md, input logic [CfgDatW-1:0] mg,
                                    input logic [CfgDatW-1:0] sp, input logic [CfgDatW-1:0] ep,
                                    input logic [CfgDatW-1:0] ps, input logic [CfgDatW-1:0] sl);
        wait_drained();
        write_register(REG_MAX_DUTY, md);
        write_register(REG_CLAMP_MARGIN, mg);
        write_register(REG_START_PERIOD, sp);
        write_register(REG_END_PERIOD, ep);
        write_register(REG_PERIOD_STEP, ps);
        write_register(REG_STEPS_LEVEL, sl);
        cfg_wr_en <= 1'b0;
    endtask

    // Random settings that keep spin-up short enough to reach running within a
    // phase: long levels only go with short start periods.
    task automatic program_random_settings();
        int unsigned levels;
        int unsigned start;
        levels = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
        start  = (levels > 4) ? $urandom_range(1, 4) : $urandom_range(1, 12);
        program_settings(CfgDatW'($urandom_range(0, 253)),
                         CfgDatW'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 40)
                                                               : $urandom_range(0, 127)),
                         CfgDatW'(start), CfgDatW'($urandom_range(0, 8)),
                         CfgDatW'($urandom_range(1, 4)), CfgDatW'(levels));
    endtask

    // Pick a command that fits the predicted motor state: mostly the sequence
    // enable, ticks through spin-up, commutate while running, with duty changes,
    // drops to idle and undefined codes mixed in as noise.
    task automatic pick_command(output logic [CmdW-1:0] code, output logic [DutyW-1:0] req);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85)
            req = DutyW'($urandom_range(255, sb.clamp_margin));
        else
            req = DutyW'($urandom_range(0, 255));
        if (sb.run_flag)
        begin
            if (roll < 50)      code = CMD_COMMUTATE;
            else if (roll < 66) code = CMD_SET_DUTY;
            else if (roll < 75) code = CMD_ENABLE;
            else if (roll < 86) code = CMD_TICK;
            else if (roll < 91) code = CMD_DISABLE;
            else                code = CmdW'($urandom_range(5, 7));
        end
        else if (sb.windup_flag)
        begin
            if (roll < 80)      code = CMD_TICK;
            else if (roll < 86) code = CMD_SET_DUTY;
            else if (roll < 90) code = CMD_ENABLE;
            else if (roll < 94) code = CMD_COMMUTATE;
            else if (roll < 96) code = CMD_DISABLE;
            else                code = CmdW'($urandom_range(5, 7));
        end
        else
        begin
            if (roll < 70)      code = CMD_ENABLE;
            else if (roll < 78) code = CMD_SET_DUTY;
            else if (roll < 84) code = CMD_TICK;
            else if (roll < 88) code = CMD_COMMUTATE;
            else if (roll < 93) code = CMD_DISABLE;
            else                code = CmdW'($urandom_range(5, 7));
        end
    endtask

    // Send random commands until the given number more have taken effect;
    // ignored commands do not advance the count.
    task automatic run_random_phase(input int unsigned target);
        int unsigned     goal;
        logic [CmdW-1:0] code;
        logic [DutyW-1:0] req;
        goal = useful_count + target;
        while (useful_count < goal)
        begin
            pick_command(code, req);
            send_command(code, req);
        end
    endtask

    initial
    begin
        sb                   = new();
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.cmd          = '0;
        cmd_bus.duty_request = '0;
        gaps_on              = 1'b1;
        stalls_on            = 1'b1;
        hold_off_len         = 0;
        useful_count         = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: ignored commands while idle, undefined codes,
        // the margin boundary, pending duty in spin-up and drops back to idle.
        send_command(CMD_TICK, 8'd0);
        send_command(CMD_COMMUTATE, 8'd255);
        send_command(CMD_SET_DUTY, 8'd128);
        send_command(3'd5, 8'd255);
        send_command(3'd6, 8'd0);
        send_command(3'd7, 8'd170);
        send_command(CMD_ENABLE, 8'd14);
        send_command(CMD_ENABLE, 8'd15);
        send_command(CMD_TICK, 8'd85);
        send_command(CMD_SET_DUTY, 8'd234);
        send_command(CMD_ENABLE, 8'd3);
        send_command(CMD_ENABLE, 8'd255);
        send_command(CMD_DISABLE, 8'd0);
        send_command(CMD_DISABLE, 8'd0);

        // Directed, start period equal to end period: enable goes straight to
        // running. Walk the phase table round once and exercise the duty clamp.
        program_settings(16'd249, 16'd15, 16'd10, 16'd10, 16'd10, 16'd6);
        send_command(CMD_ENABLE, 8'd100);
        repeat (6) send_command(CMD_COMMUTATE, 8'd0);
        send_command(CMD_SET_DUTY, 8'd240);
        send_command(CMD_ENABLE, 8'd233);
        send_command(CMD_SET_DUTY, 8'd10);
        send_command(CMD_ENABLE, 8'd0);

        // Random under reset settings: long spin-up that never completes.
        program_settings(CfgDatW'(MaxDutyRst), CfgDatW'(ClampMarginRst),
                         CfgDatW'(StartPeriodRst), CfgDatW'(EndPeriodRst),
                         CfgDatW'(PeriodStepRst), CfgDatW'(StepsLevelRst));
        run_random_phase(32);

        // Short spin-up; hold the receiver off so the block backs up its input.
        program_settings(16'd200, 16'd20, 16'd8, 16'd3, 16'd2, 16'd3);
        hold_off_len = HoldOffCycles;
        run_random_phase(72);

        // Lowest ceiling and no margin; largest period step and longest level.
        program_settings(16'd0, 16'd0, 16'd1, 16'd0, 16'd1023, 16'd15);
        run_random_phase(56);

        // Ceiling of 253 and highest margin; full-scale periods skip spin-up entirely.
        program_settings(16'd253, 16'd127, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
        run_random_phase(48);

        // Margin above the ceiling clamps every request at or above the margin; zero period step and
        // zero steps per level keep spin-up going until a drop to idle.
        program_settings(16'd100, 16'd127, 16'd4, 16'd1, 16'd0, 16'd0);
        run_random_phase(32);

        repeat (3)
        begin
            program_random_settings();
            run_random_phase(64);
        end

        // Closing stretch at full rate: no idle bursts on either side.
        program_settings(16'd249, 16'd15, 16'd6, 16'd2, 16'd1, 16'd2);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random_phase(88);

        // Drain, allow the pipeline latency to pass, then conclude.
        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
sv/bssc_pkg.sv
sv/bssc_cmd_if.sv
sv/bssc_res_if.sv
sv/bssc_cfg_regs.sv
sv/bssc_ctrl.sv
sv/bldc_six_step_commutator.sv
tb/sv/bssc_scoreboard_pkg.sv
tb/sv/testbench.sv
